### rtl/acpu_pkg.sv
// Shared types and constants of the accumulator CPU step block.
// Used by the controller, the datapath and the top level.
package acpu_pkg;

    localparam logic [1:0] CMD_EXEC  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_HALT    = 3'd1;
    localparam logic [2:0] ST_BADOP   = 3'd2;
    localparam logic [2:0] ST_BADADDR = 3'd3;
    localparam logic [2:0] ST_DEVERR  = 3'd4;
    localparam logic [2:0] ST_DIVZERO = 3'd5;

    localparam logic [4:0] OP_NOP    = 5'd0;
    localparam logic [4:0] OP_HALT   = 5'd1;
    localparam logic [4:0] OP_LOADI  = 5'd2;
    localparam logic [4:0] OP_LOADM  = 5'd3;
    localparam logic [4:0] OP_LOADX  = 5'd4;
    localparam logic [4:0] OP_STOREM = 5'd5;
    localparam logic [4:0] OP_STOREX = 5'd6;
    localparam logic [4:0] OP_SWAPAX = 5'd7;
    localparam logic [4:0] OP_COPYXA = 5'd8;
    localparam logic [4:0] OP_INCX   = 5'd9;
    localparam logic [4:0] OP_ADD    = 5'd10;
    localparam logic [4:0] OP_SUB    = 5'd11;
    localparam logic [4:0] OP_MUL    = 5'd12;
    localparam logic [4:0] OP_DIV    = 5'd13;
    localparam logic [4:0] OP_REM    = 5'd14;
    localparam logic [4:0] OP_NEG    = 5'd15;
    localparam logic [4:0] OP_JMP    = 5'd16;
    localparam logic [4:0] OP_JZ     = 5'd17;
    localparam logic [4:0] OP_JNZ    = 5'd18;
    localparam logic [4:0] OP_JN     = 5'd19;
    localparam logic [4:0] OP_JP     = 5'd20;
    localparam logic [4:0] OP_CALL   = 5'd21;
    localparam logic [4:0] OP_RET    = 5'd22;
    localparam logic [4:0] OP_IN     = 5'd23;
    localparam logic [4:0] OP_OUT    = 5'd24;

    localparam logic [31:0] PC_RESET = 32'd100;

    // memory address select
    typedef enum logic [1:0] {
        AS_PC, AS_PC1, AS_OPND, AS_OPNDX
    } t_asel;

    // register update select
    typedef enum logic [3:0] {
        RU_NONE, RU_OPW, RU_OPND, RU_DATA, RU_ALU, RU_DIV, RU_SWAP, RU_COPY,
        RU_INCX, RU_NEG, RU_IN
    } t_rupd;

    // controller -> datapath
    typedef struct packed {
        logic        clr_out;    // clear per-step outputs
        logic        host_wr;
        logic        host_rd;
        logic        mem_rd;     // read at selected address; the datapath does not use it
        logic        mem_wr;     // write at selected address
        t_asel       asel;
        logic        wd_pc2;     // write data is PC+2 (else A)
        logic        chk;        // check selected address, raise error if bad
        t_rupd       rupd;       // register load from memory read data / ops
        logic        pc_inc1;
        logic        pc_inc2;
        logic        pc_opnd;
        logic        pc_opnd1;
        logic        pc_data;
        logic        set_err;
        logic [2:0]  err_code;
        logic        err_opnd;   // detail is operand
        logic        io_out;
        logic        io_dev;
        logic        div_start;
        logic        take_dout;  // capture read data
    } t_ctl;

    // datapath -> controller
    typedef struct packed {
        logic        addr_bad;
        logic [31:0] opw;
        logic        data_zero;
        logic        acc_zero;
        logic        acc_neg;
        logic        div_done;
        logic        err_set;
    } t_sts;

endpackage

### rtl/acpu_div.sv
// Radix-2 signed divider for the accumulator CPU step block, one quotient bit per cycle.
// Depends on nothing outside this file.
module acpu_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_num,
    input  logic [31:0] i_den,
    output logic        o_done,
    output logic [31:0] o_quo,
    output logic [31:0] o_rem
);
    logic [31:0] r_q, n_q;
    logic [32:0] r_r, n_r;
    logic [31:0] r_d;
    logic        r_nneg, r_qneg;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic [32:0] trial;

    always_comb begin
        n_q = r_q;
        n_r = r_r;
        n_cnt = r_cnt;
        n_busy = r_busy;
        trial = {r_r[31:0], r_q[31]} - {1'b0, r_d};
        if (r_busy) begin
            if (!trial[32]) begin
                n_r = trial;
                n_q = {r_q[30:0], 1'b1};
            end else begin
                n_r = {r_r[31:0], r_q[31]};
                n_q = {r_q[30:0], 1'b0};
            end
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= r_busy && (r_cnt == 6'd1);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt <= 6'd32;
            end else begin
                r_busy <= n_busy;
                r_cnt <= n_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q <= i_num[31] ? (32'd0 - i_num) : i_num;
            r_d <= i_den[31] ? (32'd0 - i_den) : i_den;
            r_r <= '0;
            r_nneg <= i_num[31];
            r_qneg <= i_num[31] ^ i_den[31];
        end else begin
            r_q <= n_q;
            r_r <= n_r;
        end
    end

    assign o_quo = r_qneg ? (32'd0 - r_q) : r_q;
    assign o_rem = r_nneg ? (32'd0 - r_r[31:0]) : r_r[31:0];
endmodule

### rtl/acpu_dp.sv
// Datapath of the accumulator CPU step block: registers, word memory, ALU, divider.
// Depends on acpu_pkg and acpu_div.
module acpu_dp #(
    parameter int MEM_WORDS = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  acpu_pkg::t_ctl     i_ctl,
    output acpu_pkg::t_sts     o_sts,
    input  logic [9:0]         i_mem_addr,
    input  logic [31:0]        i_mem_data,
    input  logic [31:0]        i_io_read_data,
    output logic [9:0]         o_pc,
    output logic [31:0]        o_acc,
    output logic [31:0]        o_index_reg,
    output logic [2:0]         o_status,
    output logic [31:0]        o_error_detail,
    output logic               o_io_write_valid,
    output logic               o_io_read_valid,
    output logic [31:0]        o_io_device,
    output logic [31:0]        o_io_write_data,
    output logic [31:0]        o_read_data
);
    import acpu_pkg::*;

    localparam int AW = $clog2(MEM_WORDS);

    logic [31:0] mem [MEM_WORDS];
    logic [31:0] r_pc, r_a, r_x, r_info, r_opnd, r_rdat;
    logic [2:0]  r_err;
    logic [31:0] addr, wdata, alu, quo, remv;
    logic        bad;
    logic        host_ok;
    logic        r_hok;
    logic [AW-1:0] hidx;
    logic        r_isrem;
    logic [31:0] r_opw;
    logic        div_done;

    always_comb begin
        unique case (i_ctl.asel)
            AS_PC:    addr = r_pc;
            AS_PC1:   addr = r_pc + 32'd1;
            AS_OPND:  addr = r_opnd;
            default:  addr = r_opnd + r_x;
        endcase
    end
    assign bad = addr[31] || (addr >= 32'(MEM_WORDS));
    assign wdata = i_ctl.wd_pc2 ? (r_pc + 32'd2) : r_a;
    assign host_ok = {22'd0, i_mem_addr} < 32'(MEM_WORDS);
    assign hidx = AW'(i_mem_addr);

    always_ff @(posedge i_clk) begin
        if (i_ctl.host_wr && host_ok) begin
            mem[hidx] <= i_mem_data;
        end else if (i_ctl.mem_wr) begin
            mem[addr[AW-1:0]] <= wdata;
        end
        if (i_ctl.host_rd) begin
            r_rdat <= mem[hidx];
            r_hok <= host_ok;
        end else begin
            r_rdat <= mem[addr[AW-1:0]];
        end
    end

    always_comb begin
        unique case (r_opw[4:0])
            OP_ADD:  alu = r_a + r_rdat;
            OP_SUB:  alu = r_a - r_rdat;
            default: alu = r_a * r_rdat;
        endcase
    end

    acpu_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_ctl.div_start),
        .i_num   (r_a),
        .i_den   (r_rdat),
        .o_done  (div_done),
        .o_quo   (quo),
        .o_rem   (remv)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= PC_RESET;
            r_a <= '0;
            r_x <= '0;
            r_err <= ST_OK;
            r_info <= '0;
            o_io_write_valid <= 1'b0;
            o_io_read_valid <= 1'b0;
            o_io_device <= '0;
            o_io_write_data <= '0;
            o_read_data <= '0;
        end else begin
            if (i_ctl.clr_out) begin
                o_io_write_valid <= 1'b0;
                o_io_read_valid <= 1'b0;
                o_io_device <= '0;
                o_io_write_data <= '0;
                o_read_data <= '0;
            end
            if (i_ctl.take_dout && r_hok) begin
                o_read_data <= r_rdat;
            end
            if (i_ctl.chk && bad) begin
                r_err <= ST_BADADDR;
                r_info <= addr;
            end else if (i_ctl.set_err) begin
                r_err <= i_ctl.err_code;
                if (i_ctl.err_opnd) begin
                    r_info <= r_opnd;
                end
            end
            if (i_ctl.io_dev) begin
                o_io_device <= r_opnd;
            end
            if (i_ctl.io_out) begin
                o_io_write_valid <= 1'b1;
                o_io_write_data <= r_a;
            end
            unique case (i_ctl.rupd)
                RU_DATA:  r_a <= r_rdat;
                RU_ALU:   r_a <= alu;
                RU_DIV:   r_a <= r_isrem ? remv : quo;
                RU_SWAP: begin
                    r_a <= r_x;
                    r_x <= r_a;
                end
                RU_COPY:  r_a <= r_x;
                RU_INCX:  r_x <= r_x + 32'd1;
                RU_NEG:   r_a <= 32'd0 - r_a;
                RU_IN: begin
                    r_a <= i_io_read_data;
                    o_io_read_valid <= 1'b1;
                end
                default: ;
            endcase
            priority if (i_ctl.pc_inc1) begin
                r_pc <= r_pc + 32'd1;
            end else if (i_ctl.pc_inc2) begin
                r_pc <= r_pc + 32'd2;
            end else if (i_ctl.pc_opnd) begin
                r_pc <= r_opnd;
            end else if (i_ctl.pc_opnd1) begin
                r_pc <= r_opnd + 32'd1;
            end else if (i_ctl.pc_data) begin
                r_pc <= r_rdat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rupd == RU_OPW) begin
            r_opw <= r_rdat;
            r_isrem <= (r_rdat[4:0] == OP_REM);
        end
        if (i_ctl.rupd == RU_OPND) begin
            r_opnd <= r_rdat;
        end
    end

    assign o_sts.addr_bad  = bad;
    assign o_sts.opw       = r_opw;
    assign o_sts.data_zero = (r_rdat == 32'd0);
    assign o_sts.acc_zero  = (r_a == 32'd0);
    assign o_sts.acc_neg   = r_a[31];
    assign o_sts.div_done  = div_done;
    assign o_sts.err_set   = (r_err != ST_OK);

    assign o_pc = r_pc[9:0];
    assign o_acc = r_a;
    assign o_index_reg = r_x;
    assign o_status = r_err;
    assign o_error_detail = r_info;
endmodule

### rtl/acpu_ctrl.sv
// Controller of the accumulator CPU step block: host r/w, fetch, operand, data, divide steps.
// Depends on acpu_pkg.
module acpu_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [1:0]      i_cmd,
    input  logic            i_io_fail,
    input  acpu_pkg::t_sts  i_sts,
    output acpu_pkg::t_ctl  o_ctl,
    output logic            o_busy,
    output logic            o_done
);
    import acpu_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_HRD   = 4'd1;  // host read, data registered
    localparam logic [3:0] S_FETCH = 4'd2;  // opcode word ready
    localparam logic [3:0] S_DEC   = 4'd3;
    localparam logic [3:0] S_OPND  = 4'd4;  // operand word ready
    localparam logic [3:0] S_DATA  = 4'd5;  // data word ready
    localparam logic [3:0] S_DIV   = 4'd6;
    localparam logic [3:0] S_FIN   = 4'd7;
    localparam logic [3:0] S_EXEC  = 4'd8;  // operand known, do the action

    logic [3:0] r_st, n_st;
    logic       r_fail;
    logic [4:0] op;
    logic       valid_op;
    logic       cond;

    assign op = i_sts.opw[4:0];
    assign valid_op = (i_sts.opw[31:5] == 27'd0) && (op <= OP_OUT);

    always_comb begin
        unique case (op)
            OP_JZ:   cond = i_sts.acc_zero;
            OP_JNZ:  cond = !i_sts.acc_zero;
            OP_JN:   cond = i_sts.acc_neg;
            OP_JP:   cond = !i_sts.acc_neg && !i_sts.acc_zero;
            default: cond = 1'b1;
        endcase
    end

    always_comb begin
        o_ctl = '0;
        o_ctl.asel = AS_PC;
        o_ctl.rupd = RU_NONE;
        n_st = r_st;
        o_done = 1'b0;
        unique case (r_st)
            S_IDLE: begin
                if (i_start) begin
                    o_ctl.clr_out = 1'b1;
                    priority if (i_cmd == CMD_WRITE) begin
                        o_ctl.host_wr = 1'b1;
                        n_st = S_FIN;
                    end else if (i_cmd == CMD_READ) begin
                        o_ctl.host_rd = 1'b1;
                        n_st = S_HRD;
                    end else if (i_cmd == CMD_EXEC && !i_sts.err_set) begin
                        o_ctl.chk = 1'b1;
                        n_st = i_sts.addr_bad ? S_FIN : S_FETCH;
                    end else begin
                        n_st = S_FIN;
                    end
                end
            end
            S_HRD: begin
                o_ctl.take_dout = 1'b1;
                n_st = S_FIN;
            end
            S_FETCH: begin
                o_ctl.rupd = RU_OPW;
                n_st = S_DEC;
            end
            S_DEC: begin
                n_st = S_FIN;
                if (!valid_op) begin
                    o_ctl.set_err = 1'b1;
                    o_ctl.err_code = ST_BADOP;
                end else begin
                    unique case (op)
                        OP_NOP:    o_ctl.pc_inc1 = 1'b1;
                        OP_HALT: begin
                            o_ctl.set_err = 1'b1;
                            o_ctl.err_code = ST_HALT;
                        end
                        OP_SWAPAX: begin
                            o_ctl.rupd = RU_SWAP;
                            o_ctl.pc_inc1 = 1'b1;
                        end
                        OP_COPYXA: begin
                            o_ctl.rupd = RU_COPY;
                            o_ctl.pc_inc1 = 1'b1;
                        end
                        OP_INCX: begin
                            o_ctl.rupd = RU_INCX;
                            o_ctl.pc_inc1 = 1'b1;
                        end
                        OP_NEG: begin
                            o_ctl.rupd = RU_NEG;
                            o_ctl.pc_inc1 = 1'b1;
                        end
                        OP_JMP, OP_JZ, OP_JNZ, OP_JN, OP_JP: begin
                            if (!cond) begin
                                o_ctl.pc_inc2 = 1'b1;
                            end else begin
                                o_ctl.asel = AS_PC1;
                                o_ctl.chk = 1'b1;
                                if (!i_sts.addr_bad) n_st = S_OPND;
                            end
                        end
                        default: begin
                            o_ctl.asel = AS_PC1;
                            o_ctl.chk = 1'b1;
                            if (!i_sts.addr_bad) n_st = S_OPND;
                        end
                    endcase
                end
            end
            S_OPND: begin
                // keep the operand word on the read port for LOADI
                o_ctl.asel = AS_PC1;
                o_ctl.rupd = RU_OPND;
                n_st = S_EXEC;
            end
            S_EXEC: begin
                n_st = S_FIN;
                unique case (op)
                    OP_LOADI: begin
                        o_ctl.pc_inc2 = 1'b1;
                        o_ctl.rupd = RU_DATA;
                    end
                    OP_JMP, OP_JZ, OP_JNZ, OP_JN, OP_JP: o_ctl.pc_opnd = 1'b1;
                    OP_STOREM, OP_STOREX, OP_CALL: begin
                        o_ctl.asel = (op == OP_STOREX) ? AS_OPNDX : AS_OPND;
                        o_ctl.wd_pc2 = (op == OP_CALL);
                        o_ctl.chk = 1'b1;
                        if (!i_sts.addr_bad) begin
                            o_ctl.mem_wr = 1'b1;
                            if (op == OP_CALL) o_ctl.pc_opnd1 = 1'b1;
                            else o_ctl.pc_inc2 = 1'b1;
                        end
                    end
                    OP_IN, OP_OUT: begin
                        o_ctl.io_dev = 1'b1;
                        if (r_fail) begin
                            o_ctl.set_err = 1'b1;
                            o_ctl.err_code = ST_DEVERR;
                            o_ctl.err_opnd = 1'b1;
                        end else begin
                            o_ctl.pc_inc2 = 1'b1;
                            if (op == OP_IN) o_ctl.rupd = RU_IN;
                            else o_ctl.io_out = 1'b1;
                        end
                    end
                    default: begin
                        // memory operand read: LOADM, LOADX, ALU ops, DIV, REM, RET
                        o_ctl.asel = (op == OP_LOADX) ? AS_OPNDX : AS_OPND;
                        o_ctl.chk = 1'b1;
                        if (!i_sts.addr_bad) n_st = S_DATA;
                    end
                endcase
            end
            S_DATA: begin
                n_st = S_FIN;
                unique case (op)
                    OP_LOADM, OP_LOADX: begin
                        o_ctl.rupd = RU_DATA;
                        o_ctl.pc_inc2 = 1'b1;
                    end
                    OP_RET: o_ctl.pc_data = 1'b1;
                    OP_ADD, OP_SUB, OP_MUL: begin
                        o_ctl.rupd = RU_ALU;
                        o_ctl.pc_inc2 = 1'b1;
                    end
                    default: begin
                        if (i_sts.data_zero) begin
                            o_ctl.set_err = 1'b1;
                            o_ctl.err_code = ST_DIVZERO;
                            o_ctl.err_opnd = 1'b1;
                        end else begin
                            o_ctl.div_start = 1'b1;
                            n_st = S_DIV;
                        end
                    end
                endcase
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    o_ctl.rupd = RU_DIV;
                    o_ctl.pc_inc2 = 1'b1;
                    n_st = S_FIN;
                end
            end
            S_FIN: begin
                o_done = 1'b1;
                n_st = S_IDLE;
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_fail <= 1'b0;
        end else begin
            r_st <= n_st;
            if (i_start && r_st == S_IDLE) begin
                r_fail <= i_io_fail;
            end
        end
    end

    assign o_busy = (r_st != S_IDLE);
endmodule

### rtl/accumulator_cpu_step.sv
// Top level of the accumulator CPU step block.
// Depends on acpu_pkg, acpu_ctrl, acpu_dp.
//
// One command per start pulse; busy stays high until the result strobe.
// Memory load and readback use one memory access; an instruction makes
// up to three sequential word-memory accesses through one port and ends
// at once when an error is already recorded or the PC is out of range;
// DIV/REM also wait for the radix-2 divider.
// The result shows for exactly one cycle with o_done high and cannot be
// held off. io_read_data and io_fail are sampled together with start.
module accumulator_cpu_step #(
    parameter int MEM_WORDS = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    output logic        o_done,
    input  logic [1:0]  i_cmd,
    input  logic [9:0]  i_mem_addr,
    input  logic [31:0] i_mem_data,
    input  logic [31:0] i_io_read_data,
    input  logic        i_io_fail,
    output logic [9:0]  o_pc,
    output logic [31:0] o_acc,
    output logic [31:0] o_index_reg,
    output logic [2:0]  o_status,
    output logic [31:0] o_error_detail,
    output logic        o_io_write_valid,
    output logic        o_io_read_valid,
    output logic [31:0] o_io_device,
    output logic [31:0] o_io_write_data,
    output logic [31:0] o_read_data
);
    import acpu_pkg::*;

    t_ctl        ctl;
    t_sts        sts;
    logic [31:0] r_iodat;

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_iodat <= i_io_read_data;
        end
    end

    acpu_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_cmd     (i_cmd),
        .i_io_fail (i_io_fail),
        .i_sts     (sts),
        .o_ctl     (ctl),
        .o_busy    (busy),
        .o_done    (o_done)
    );

    acpu_dp #(.MEM_WORDS(MEM_WORDS)) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_ctl            (ctl),
        .o_sts            (sts),
        .i_mem_addr       (i_mem_addr),
        .i_mem_data       (i_mem_data),
        .i_io_read_data   (r_iodat),
        .o_pc             (o_pc),
        .o_acc            (o_acc),
        .o_index_reg      (o_index_reg),
        .o_status         (o_status),
        .o_error_detail   (o_error_detail),
        .o_io_write_valid (o_io_write_valid),
        .o_io_read_valid  (o_io_read_valid),
        .o_io_device      (o_io_device),
        .o_io_write_data  (o_io_write_data),
        .o_read_data      (o_read_data)
    );
endmodule
